// ===== rtl/sand_water_grid_automaton_top_macros.svh =====
// assertion macros for the sand and water grid block
// used by the port checker only
`ifndef SAND_WATER_GRID_AUTOMATON_TOP_MACROS_SVH
`define SAND_WATER_GRID_AUTOMATON_TOP_MACROS_SVH
// checked outside reset
`define SWG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset too
`define SWG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/swg_pkg.sv =====
// package for the sand and water grid block: sizes, codes, states, helpers
// no dependencies
`timescale 1ns / 1ps
package swg_pkg;
  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 128;
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH = 1 << ADDR_W;
  localparam int IW = 5;
  localparam int EW = COL_W + IW;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ = 3'd1;
  localparam logic [2:0] CMD_SAND = 3'd2;
  localparam logic [2:0] CMD_WATER = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] MAT_EMPTY = 2'd0;
  localparam logic [1:0] MAT_SAND = 2'd1;
  localparam logic [1:0] MAT_WATER = 2'd2;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_REACH = 2'd1;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [3:0] REACH_DEFAULT = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_RQ, ST_RD, ST_WR, ST_FIN,
    ST_S_ROW, ST_W_START, ST_CUR, ST_CUR_D, ST_S_BEL_D, ST_W_BEL_D,
    ST_W_DIR, ST_W_SRCH, ST_W_SRCH_D, ST_W_DROP_D,
    ST_L, ST_L_D, ST_R, ST_R_D, ST_S_DEC, ST_W_DEC, ST_W_D3, ST_W_D2,
    ST_W2, ST_ADV
  } state_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // base-4 digit sum keeps the value mod 3
  function automatic logic mod3_zero(input logic [15:0] s);
    logic [4:0] v;
    v = 5'd0;
    for (int k = 0; k < 8; k++) v = v + {3'd0, s[2*k +: 2]};
    if (v >= 5'd24) v = v - 5'd24;
    if (v >= 5'd12) v = v - 5'd12;
    if (v >= 5'd6) v = v - 5'd6;
    if (v >= 5'd3) v = v - 5'd3;
    return v == 5'd0;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] yy,
                                                  input logic [COL_W-1:0] xx);
    return {yy, xx};
  endfunction
endpackage

// ===== rtl/swg_ram.sv =====
// generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module swg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sand_water_grid_automaton_top.sv =====
// A write or read goes ST_RQ, then ST_RD or ST_WR, then ST_FIN (ST_RQ to ST_FIN when ignored);
// unused codes go straight to ST_FIN, clear first sweeps all DEPTH (16384) cells; the input is
// free again as the result appears. A pass walks every cell through the grid ram, one read per
// cycle; a sand pass also steps through ST_S_ROW at the start of each row.
// Reset (synchronous, rst high) loads seed 44257 and reach 8, then sweeps all 16384 cells
// to empty with no item accepted; config writes are taken only while idle.
// top level of the sand and water grid block; uses swg_pkg and swg_ram
`timescale 1ns / 1ps
module sand_water_grid_automaton_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // cmd[2:0] col[10:3] row[18:11] material[20:19] force_write[21]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // cell_value[1:0] write_taken[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import swg_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(GRID_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(GRID_ROWS - 1);

  state_t st, st_next;
  logic [2:0] cmd_q;
  logic [7:0] col_q, row_q;
  logic [1:0] mat_q;
  logic frc_q, rep;
  logic [ROW_W-1:0] y;
  logic [COL_W-1:0] x;
  logic ltr, dir, lflag, rflag;
  logic [IW-1:0] i;
  logic [ADDR_W-1:0] w2_addr, clr_cnt;
  logic [1:0] w2_val, res_val, out_val;
  logic res_taken, out_taken, out_valid;
  logic [15:0] rng;
  logic [3:0] reach;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [1:0] wdata, rd;

  swg_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  logic s_acc, psand, below, in_grid, last_cell, even, m3, i_oor, i_over;
  logic cur_hit, s_left;
  logic [COL_W-1:0] cx, nx;
  logic [ROW_W-1:0] yb, sy;
  logic [15:0] draw_s;
  logic [EW-1:0] wcx, wi;

  assign s_acc = s_tvalid && s_tready;
  assign s_tready = (st == ST_IDLE);
  assign cfg_ready = (st == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = {5'd0, out_taken, out_val};

  assign psand = (cmd_q == CMD_SAND);
  assign cx = ltr ? x : COL_MAX - x;
  assign yb = y + ROW_W'(1);
  assign sy = psand ? yb : y;
  assign below = (y != ROW_MAX);
  assign last_cell = (x == COL_MAX);
  assign in_grid = ({1'b0, col_q} < 9'(GRID_COLS)) && ({1'b0, row_q} < 9'(GRID_ROWS));
  assign draw_s = lfsr_step(rng);
  assign even = !draw_s[0];
  assign m3 = mod3_zero(draw_s);
  assign wcx = EW'(cx);
  assign wi = EW'(i);
  assign i_oor = dir ? (wi > wcx) : (wcx + wi > EW'(GRID_COLS - 1));
  assign i_over = (i > {1'b0, reach});
  assign nx = dir ? cx - COL_W'(i) : cx + COL_W'(i);
  assign cur_hit = (rd == (psand ? MAT_SAND : MAT_WATER));
  assign s_left = (lflag && rflag) ? even : lflag;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (s_acc) begin
          case (s_tdata[2:0])
            CMD_WRITE, CMD_READ: st_next = ST_RQ;
            CMD_SAND: st_next = ST_S_ROW;
            CMD_WATER: st_next = ST_W_START;
            CMD_CLEAR: st_next = ST_CLEAR;
            default: st_next = ST_FIN;
          endcase
        end
      end
      ST_CLEAR: if (clr_cnt == ADDR_W'(DEPTH - 1)) st_next = rep ? ST_FIN : ST_IDLE;
      ST_RQ: begin
        if (!in_grid || (cmd_q == CMD_WRITE && mat_q == 2'd3)) st_next = ST_FIN;
        else st_next = (cmd_q == CMD_WRITE) ? ST_WR : ST_RD;
      end
      ST_RD, ST_WR: st_next = ST_FIN;
      ST_FIN: if (!out_valid || m_tready) st_next = ST_IDLE;
      ST_S_ROW, ST_W_START: st_next = ST_CUR;
      ST_CUR: st_next = ST_CUR_D;
      ST_CUR_D: begin
        if (!cur_hit) st_next = ST_ADV;
        else if (!below) st_next = psand ? ST_ADV : ST_W_DIR;
        else st_next = psand ? ST_S_BEL_D : ST_W_BEL_D;
      end
      ST_S_BEL_D: st_next = (rd == MAT_EMPTY || rd == MAT_WATER) ? ST_W2 : ST_L;
      ST_W_BEL_D: st_next = (rd == MAT_EMPTY) ? ST_W2 : ST_W_DIR;
      ST_W_DIR: st_next = ST_W_SRCH;
      ST_W_SRCH: st_next = (i_over || i_oor) ? ST_L : ST_W_SRCH_D;
      ST_W_SRCH_D: begin
        if (rd != MAT_EMPTY) st_next = ST_L;
        else st_next = below ? ST_W_DROP_D : ST_W_SRCH;
      end
      ST_W_DROP_D: st_next = (rd == MAT_EMPTY) ? ST_W2 : ST_W_SRCH;
      ST_L: st_next = (cx != '0) ? ST_L_D : ST_R;
      ST_L_D: st_next = ST_R;
      ST_R: begin
        if (cx != COL_MAX) st_next = ST_R_D;
        else st_next = psand ? ST_S_DEC : ST_W_DEC;
      end
      ST_R_D: st_next = psand ? ST_S_DEC : ST_W_DEC;
      ST_S_DEC: st_next = (lflag || rflag) ? ST_W2 : ST_ADV;
      ST_W_DEC: begin
        if (lflag ^ rflag) st_next = ST_W2;
        else if (lflag) st_next = ST_W_D3;
        else st_next = ST_ADV;
      end
      ST_W_D3: st_next = m3 ? ST_W_D2 : ST_ADV;
      ST_W_D2: st_next = ST_W2;
      ST_W2: st_next = ST_ADV;
      ST_ADV: begin
        if (!last_cell) st_next = ST_CUR;
        else if (y == '0) st_next = ST_FIN;
        else st_next = psand ? ST_S_ROW : ST_CUR;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // grid ram control
  always_comb begin
    we = 1'b0;
    waddr = cell_addr(y, cx);
    wdata = MAT_EMPTY;
    raddr = cell_addr(y, cx);
    case (st)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
      end
      ST_RQ: raddr = cell_addr(row_q[ROW_W-1:0], col_q[COL_W-1:0]);
      ST_WR: begin
        waddr = cell_addr(row_q[ROW_W-1:0], col_q[COL_W-1:0]);
        wdata = mat_q;
        we = frc_q || (rd == MAT_EMPTY);
      end
      ST_CUR_D: raddr = cell_addr(yb, cx);
      ST_S_BEL_D: begin
        we = (rd == MAT_EMPTY || rd == MAT_WATER);
        wdata = rd;
      end
      ST_W_BEL_D, ST_W_DROP_D: we = (rd == MAT_EMPTY);
      ST_W_SRCH: raddr = cell_addr(y, nx);
      ST_W_SRCH_D: raddr = cell_addr(yb, nx);
      ST_L: raddr = cell_addr(sy, cx - COL_W'(1));
      ST_R: raddr = cell_addr(sy, cx + COL_W'(1));
      ST_S_DEC: we = lflag || rflag;
      ST_W_DEC: we = lflag ^ rflag;
      ST_W_D2: we = 1'b1;
      ST_W2: begin
        we = 1'b1;
        waddr = w2_addr;
        wdata = w2_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
      rep <= 1'b0;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      rng <= SEED_DEFAULT;
      reach <= REACH_DEFAULT;
    end else begin
      st <= st_next;
      case (st)
        ST_IDLE: begin
          if (s_acc) begin
            cmd_q <= s_tdata[2:0];
            col_q <= s_tdata[10:3];
            row_q <= s_tdata[18:11];
            mat_q <= s_tdata[20:19];
            frc_q <= s_tdata[21];
            res_val <= MAT_EMPTY;
            res_taken <= 1'b0;
            y <= ROW_MAX;
            x <= '0;
            clr_cnt <= '0;
            rep <= 1'b1;
          end
        end
        ST_CLEAR: clr_cnt <= clr_cnt + ADDR_W'(1);
        ST_RD: res_val <= rd;
        ST_WR: res_taken <= (frc_q || rd == MAT_EMPTY) && (rd != mat_q);
        ST_S_ROW, ST_W_START: begin
          rng <= draw_s;
          ltr <= even;
          x <= '0;
        end
        ST_S_BEL_D: begin
          w2_addr <= cell_addr(yb, cx);
          w2_val <= MAT_SAND;
        end
        ST_W_BEL_D: begin
          w2_addr <= cell_addr(yb, cx);
          w2_val <= MAT_WATER;
        end
        ST_W_DIR: begin
          rng <= draw_s;
          dir <= even;
          i <= IW'(1);
        end
        ST_W_SRCH_D: if (rd == MAT_EMPTY && !below) i <= i + IW'(1);
        ST_W_DROP_D: begin
          w2_addr <= cell_addr(y, nx);
          w2_val <= MAT_WATER;
          if (rd != MAT_EMPTY) i <= i + IW'(1);
        end
        ST_L: if (cx == '0) lflag <= 1'b0;
        ST_L_D: lflag <= (rd == MAT_EMPTY);
        ST_R: if (cx == COL_MAX) rflag <= 1'b0;
        ST_R_D: rflag <= (rd == MAT_EMPTY);
        ST_S_DEC: begin
          if (lflag && rflag) rng <= draw_s;
          w2_addr <= cell_addr(yb, s_left ? cx - COL_W'(1) : cx + COL_W'(1));
          w2_val <= MAT_SAND;
        end
        ST_W_DEC: begin
          w2_addr <= cell_addr(y, lflag ? cx - COL_W'(1) : cx + COL_W'(1));
          w2_val <= MAT_WATER;
        end
        ST_W_D3: rng <= draw_s;
        ST_W_D2: begin
          rng <= draw_s;
          w2_addr <= cell_addr(y, even ? cx - COL_W'(1) : cx + COL_W'(1));
          w2_val <= MAT_WATER;
        end
        ST_ADV: begin
          if (last_cell) begin
            x <= '0;
            y <= y - ROW_W'(1);
          end else begin
            x <= x + COL_W'(1);
          end
        end
        default: ;
      endcase
      if (st == ST_FIN && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
        out_val <= res_val;
        out_taken <= res_taken;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEED) rng <= (cfg_data == 16'd0) ? SEED_DEFAULT : cfg_data;
        else if (cfg_index == REG_REACH) reach <= cfg_data[3:0];
      end
    end
  end
endmodule

// ===== rtl/swg_checker.sv =====
// port-level checker for the sand and water grid block, bound to the top level
// uses the assertion macros header
`timescale 1ns / 1ps
`include "sand_water_grid_automaton_top_macros.svh"
module swg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);
  logic unused;
  assign unused = ^{s_tvalid, s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  `SWG_ASSERT_RST(a_reset_sweep, rst |=> !s_tready && !m_tvalid, "reset must start the clear sweep")
  `SWG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `SWG_ASSERT(a_busy_after_item, s_tvalid && s_tready |=> !s_tready, "item accepted while busy")
  `SWG_ASSERT(a_value_code, m_tvalid |-> m_tdata[1:0] != 2'd3, "bad cell value code")
  `SWG_ASSERT(a_read_xor_write, m_tvalid |-> !(m_tdata[2] && m_tdata[1:0] != 2'd0), "value and taken both set")
endmodule

bind sand_water_grid_automaton_top swg_checker u_swg_checker (.*);
